// ===== hw/rtl/grid_raycast_column_dda_core_defines.svh =====
// Assertion macros for the raycast column core.
`ifndef GRID_RAYCAST_COLUMN_DDA_CORE_DEFINES_SVH
`define GRID_RAYCAST_COLUMN_DDA_CORE_DEFINES_SVH

`ifndef SYNTH
`define GRCD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GRCD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GRCD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define GRCD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/grcd_pkg.sv =====
package grcd_pkg;

  localparam int GRID_BITS   = 4;
  localparam int MAX_STEPS   = 32;
  localparam int STEP_W      = $clog2(MAX_STEPS);
  localparam int SCREEN_ROWS = 256;
  localparam int HALF_COLS   = 256;
  localparam int DIV_NUM_W   = 32;
  localparam int DIV_DEN_W   = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);
  localparam int RECIP_W     = 24;
  localparam int SIDE_W      = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 64;

  typedef struct packed {
    logic [8:0]         column;
    logic [15:0]        cam_x;
    logic [15:0]        cam_y;
    logic signed [15:0] view_dir_x;
    logic signed [15:0] view_dir_y;
    logic signed [15:0] plane_dir_x;
    logic signed [15:0] plane_dir_y;
  } grcd_in_t;

  typedef struct packed {
    logic [8:0]  column_out;
    logic        wall_side;
    logic [3:0]  hit_cell_x;
    logic [3:0]  hit_cell_y;
    logic [15:0] wall_distance;
    logic [8:0]  line_height;
    logic [7:0]  draw_top;
    logic [7:0]  draw_bottom;
    logic        no_hit;
  } grcd_out_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } grcd_div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } grcd_div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RAYX, ST_RAYY, ST_RCPX, ST_WRCPX, ST_RCPY, ST_WRCPY,
    ST_INITX, ST_INITY, ST_WALK, ST_DIST, ST_WDIST, ST_LH, ST_WLH, ST_FIN
  } grcd_state_t;

endpackage

// ===== hw/rtl/grcd_div.sv =====
module grcd_div (
  input  logic                   clk,
  input  logic                   rst,
  input  grcd_pkg::grcd_div_req_t req,
  output grcd_pkg::grcd_div_rsp_t rsp
);
  import grcd_pkg::*;

  logic                 active;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 fits;

  // One quotient bit per cycle, restoring; a zero divisor yields all ones.
  assign rem_sh = {rem, quo[DIV_NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.num;
      den <= req.den;
      rem <= '0;
    end else if (active) begin
      quo <= {quo[DIV_NUM_W-2:0], fits};
      rem <= fits ? DIV_DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DIV_DEN_W-1:0];
    end
  end

  assign rsp.busy = active;
  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

// ===== hw/rtl/grid_raycast_column_dda_core.sv =====
// Casts one ray per screen column through a 16x16 wall grid by DDA and reports
// the wall side, hit cell, perpendicular distance, line height and draw span.
// One request is worked at a time: input ready is high only while idle. Each
// division runs on the single bit-serial divider: a start, 32 quotient bits
// and a done strobe. A column that hits a wall runs four of them (two
// reciprocal step lengths, the wall distance and the line height) and walks
// 1 to 32 grid steps between setup and finish. A column with no hit skips the
// last two divisions. The finished result sits in an output register, so the
// next request is taken while it waits. The user must write map registers only
// while idle; the block itself does not enforce it.
module grid_raycast_column_dda_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  grcd_pkg::grcd_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output grcd_pkg::grcd_out_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [grcd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [grcd_pkg::CFG_W-1:0]           cfg_wdata
);
  import grcd_pkg::*;
  `include "grid_raycast_column_dda_core_defines.svh"

  grcd_state_t state, state_next;
  grcd_div_req_t div_req;
  grcd_div_rsp_t div_rsp;

  logic [CFG_W-1:0]      map_reg [4];
  logic [255:0]          map_flat;
  grcd_in_t              item;
  logic signed [15:0]    rx, ry;
  logic [RECIP_W-1:0]    dx, dy;
  logic [SIDE_W-1:0]     distx, disty;
  logic [GRID_BITS-1:0]  mx, my;
  logic                  side;
  logic                  hit;
  logic [STEP_W-1:0]     steps;
  logic [15:0]           wall_dist;
  logic [8:0]            lh;

  // ray component: dir + floor(plane*(column-256)/256), saturated
  logic signed [15:0] ray_dir, ray_plane;
  logic signed [9:0]  col_off;
  logic signed [25:0] ray_prod;
  logic signed [17:0] ray_sum;
  logic signed [15:0] ray_sat;

  assign col_off   = $signed({1'b0, item.column}) - 10'sd256;
  assign ray_dir   = (state == ST_RAYX) ? item.view_dir_x : item.view_dir_y;
  assign ray_plane = (state == ST_RAYX) ? item.plane_dir_x : item.plane_dir_y;
  assign ray_prod  = ray_plane * col_off;
  assign ray_sum   = 18'(ray_dir) + 18'(ray_prod >>> 8);
  assign ray_sat   = (ray_sum > 18'sd32767) ? 16'sd32767 :
                     (ray_sum < -18'sd32768) ? -16'sd32768 : ray_sum[15:0];

  logic [15:0] mag_x, mag_y;
  assign mag_x = rx[15] ? 16'(-rx) : 16'(rx);
  assign mag_y = ry[15] ? 16'(-ry) : 16'(ry);

  // initial side distance, one product per cycle
  logic [11:0] frac;
  logic        neg;
  logic [12:0] f;
  logic [RECIP_W-1:0] d_sel;
  logic [36:0] init_prod;
  assign frac      = (state == ST_INITX) ? item.cam_x[11:0] : item.cam_y[11:0];
  assign neg       = (state == ST_INITX) ? rx[15] : ry[15];
  assign f         = neg ? {1'b0, frac} : 13'd4096 - {1'b0, frac};
  assign d_sel     = (state == ST_INITX) ? dx : dy;
  assign init_prod = f * d_sel;

  // one grid step
  logic                 step_x, leave, wall;
  logic [GRID_BITS-1:0] nx, ny;
  assign map_flat = {map_reg[3], map_reg[2], map_reg[1], map_reg[0]};
  assign step_x   = distx < disty;
  always_comb begin
    nx    = mx;
    ny    = my;
    leave = 1'b0;
    if (step_x) begin
      leave = rx[15] ? (mx == '0) : (mx == '1);
      nx    = rx[15] ? mx - 1'b1 : mx + 1'b1;
    end else begin
      leave = ry[15] ? (my == '0) : (my == '1);
      ny    = ry[15] ? my - 1'b1 : my + 1'b1;
    end
  end
  assign wall = map_flat[{nx, ny}];

  // perpendicular distance numerator |edge - cam| * 512
  logic [4:0]         edge_cell;
  logic [16:0]        edge_pos;
  logic signed [17:0] edge_diff;
  logic [16:0]        edge_mag;
  assign edge_cell = side ? ({1'b0, my} + 5'(ry[15])) : ({1'b0, mx} + 5'(rx[15]));
  assign edge_pos  = {edge_cell, 12'd0};
  assign edge_diff = $signed({1'b0, edge_pos}) -
                     $signed({2'b00, (side ? item.cam_y : item.cam_x)});
  assign edge_mag  = edge_diff[17] ? 17'(-edge_diff) : edge_diff[16:0];

  grcd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_RAYX;
      ST_RAYX:  state_next = ST_RAYY;
      ST_RAYY:  state_next = ST_RCPX;
      ST_RCPX:  state_next = ST_WRCPX;
      ST_WRCPX: if (div_rsp.done) state_next = ST_RCPY;
      ST_RCPY:  state_next = ST_WRCPY;
      ST_WRCPY: if (div_rsp.done) state_next = ST_INITX;
      ST_INITX: state_next = ST_INITY;
      ST_INITY: state_next = ST_WALK;
      ST_WALK: begin
        if (!leave && wall) state_next = ST_DIST;
        else if (leave || steps == STEP_W'(MAX_STEPS - 1)) state_next = ST_FIN;
      end
      ST_DIST:  state_next = ST_WDIST;
      ST_WDIST: if (div_rsp.done) state_next = ST_LH;
      ST_LH:    state_next = ST_WLH;
      ST_WLH:   if (div_rsp.done) state_next = ST_FIN;
      ST_FIN:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_RCPX: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'(1) << 29;
        div_req.den   = mag_x;
      end
      ST_RCPY: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'(1) << 29;
        div_req.den   = mag_y;
      end
      ST_DIST: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'({edge_mag, 9'd0});
        div_req.den   = side ? mag_y : mag_x;
      end
      ST_LH: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'(SCREEN_ROWS * 256);
        div_req.den   = wall_dist;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      map_reg[0] <= '0;
      map_reg[1] <= '0;
      map_reg[2] <= '0;
      map_reg[3] <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) map_reg[cfg_index] <= cfg_wdata;
      if (state == ST_FIN && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (in_valid) item <= in_data;
      ST_RAYX: rx <= ray_sat;
      ST_RAYY: ry <= ray_sat;
      ST_WRCPX: if (div_rsp.done)
        dx <= (div_rsp.quo[DIV_NUM_W-1:RECIP_W] != '0) ? '1 : div_rsp.quo[RECIP_W-1:0];
      ST_WRCPY: if (div_rsp.done)
        dy <= (div_rsp.quo[DIV_NUM_W-1:RECIP_W] != '0) ? '1 : div_rsp.quo[RECIP_W-1:0];
      ST_INITX: begin
        distx <= SIDE_W'(init_prod[36:12]);
        mx    <= item.cam_x[15:12];
        my    <= item.cam_y[15:12];
        steps <= '0;
        hit   <= 1'b0;
      end
      ST_INITY: disty <= SIDE_W'(init_prod[36:12]);
      ST_WALK: begin
        if (step_x) distx <= distx + SIDE_W'(dx);
        else        disty <= disty + SIDE_W'(dy);
        mx    <= nx;
        my    <= ny;
        side  <= !step_x;
        steps <= steps + 1'b1;
        hit   <= !leave && wall;
      end
      ST_WDIST: if (div_rsp.done)
        wall_dist <= (div_rsp.quo[DIV_NUM_W-1:16] != '0) ? '1 : div_rsp.quo[15:0];
      ST_WLH: if (div_rsp.done)
        lh <= (div_rsp.quo > DIV_NUM_W'(SCREEN_ROWS)) ? 9'(SCREEN_ROWS) : div_rsp.quo[8:0];
      ST_FIN: if (!out_valid || out_ready) begin
        out_data.column_out <= item.column;
        out_data.no_hit     <= !hit;
        if (hit) begin
          out_data.wall_side     <= side;
          out_data.hit_cell_x    <= mx;
          out_data.hit_cell_y    <= my;
          out_data.wall_distance <= wall_dist;
          out_data.line_height   <= lh;
          out_data.draw_top      <= 8'(SCREEN_ROWS / 2 - int'(lh[8:1]));
          out_data.draw_bottom   <= lh[8] ? 8'(SCREEN_ROWS - 1)
                                          : 8'(SCREEN_ROWS / 2 + int'(lh[8:1]));
        end else begin
          out_data.wall_side     <= 1'b0;
          out_data.hit_cell_x    <= '0;
          out_data.hit_cell_y    <= '0;
          out_data.wall_distance <= '1;
          out_data.line_height   <= '0;
          out_data.draw_top      <= 8'(SCREEN_ROWS / 2);
          out_data.draw_bottom   <= 8'(SCREEN_ROWS / 2);
        end
      end
      default: ;
    endcase
  end

  `GRCD_ASSERT_NXT(a_accept_starts, clk, rst, in_valid && in_ready, state == ST_RAYX, "no start")
  `GRCD_ASSERT_IMP(a_start_idle_div, clk, rst, div_req.start, !div_rsp.busy, "divider busy")
  `GRCD_ASSERT_NXT(a_fin_publishes, clk, rst, state == ST_FIN && !out_valid, out_valid, "no result")
  `GRCD_ASSERT_IMP(a_ready_only_idle, clk, rst, in_ready, state == ST_IDLE, "ready outside idle")

endmodule
